FILE: hw/rtl/cbf_pkg.sv
package cbf_pkg;

    // fixed field widths
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int DIST_W   = COORD_W + 2;
    localparam int T_W      = 17;
    localparam int IDX_W    = 6;
    localparam int CFG_W    = 8;
    localparam int FIX_W    = 32;
    localparam int DIV_W    = DIST_W;

    localparam logic [CFG_W-1:0] CFG_STEP_RESET = 8'd8;
    // t = 1.0 in Q1.16, the dividend of the per-step increment
    localparam logic [DIV_W-1:0] T_ONE = 18'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMS,
        ST_MAXD,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_STEPS,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_WALK_INIT,
        ST_ISSUE
    } t_state;

    typedef enum logic {
        DIV_STEPS,
        DIV_RECIP
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     sums;
        logic     maxd;
        logic     div_start;
        t_div_sel div_sel;
        logic     steps_latch;
        logic     walk_init;
        logic     issue;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic adv;
        logic walk_last;
    } t_status;

endpackage

FILE: hw/rtl/cbf_divider.sv
module cbf_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cbf_pkg::DIV_W-1:0] i_dividend,
    input  logic [cbf_pkg::CFG_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [cbf_pkg::DIV_W-1:0] o_quot,
    output logic [cbf_pkg::CFG_W-1:0] o_rem
);
    import cbf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quot;
    logic [CFG_W-1:0] r_rem;
    logic [CFG_W-1:0] r_div;

    logic [CFG_W:0]   shifted;
    logic             ge;
    logic [CFG_W:0]   diff;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        shifted = {r_rem, r_quot[DIV_W-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = shifted >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], ge};
            r_rem  <= ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/cbf_ctrl.sv
module cbf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cbf_pkg::t_status i_status,
    output cbf_pkg::t_cmd    o_cmd
);
    import cbf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SUMS;
            end
            ST_SUMS:      n_state = ST_MAXD;
            ST_MAXD:      n_state = ST_DIV1_GO;
            ST_DIV1_GO:   n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: begin
                if (!i_status.div_busy) n_state = ST_STEPS;
            end
            ST_STEPS:     n_state = ST_DIV2_GO;
            ST_DIV2_GO:   n_state = ST_DIV2_WAIT;
            ST_DIV2_WAIT: begin
                if (!i_status.div_busy) n_state = ST_WALK_INIT;
            end
            ST_WALK_INIT: n_state = ST_ISSUE;
            ST_ISSUE: begin
                if (i_status.adv && i_status.walk_last) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_STEPS;
        o_in_stall    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                // no word is taken while reset is held
                o_in_stall = !i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_SUMS:      o_cmd.sums = 1'b1;
            ST_MAXD:      o_cmd.maxd = 1'b1;
            ST_DIV1_GO:   o_cmd.div_start = 1'b1;
            ST_STEPS:     o_cmd.steps_latch = 1'b1;
            ST_DIV2_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_RECIP;
            end
            ST_WALK_INIT: o_cmd.walk_init = 1'b1;
            ST_ISSUE:     o_cmd.issue = i_status.adv;
            default:      o_cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/cbf_datapath.sv
module cbf_datapath #(
    parameter int MAX_STEPS = 63
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [cbf_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl1_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl1_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl2_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl2_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_end_y,
    input  cbf_pkg::t_cmd                      i_cmd,
    output cbf_pkg::t_status                   o_status,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic signed [cbf_pkg::COORD_W-1:0] o_point_x,
    output logic signed [cbf_pkg::COORD_W-1:0] o_point_y,
    output logic        [cbf_pkg::IDX_W-1:0]   o_point_index,
    output logic                               o_last
);
    import cbf_pkg::*;

    // first interpolation round: p + d * t, the shift brings p to the Q16 scale
    function automatic logic signed [FIX_W-1:0] lerp_base(
        input logic signed [COORD_W-1:0] p,
        input logic signed [DIFF_W-1:0]  d,
        input logic        [T_W-1:0]     t
    );
        logic signed [DIFF_W+T_W:0] prod;
        logic        [DIFF_W+T_W+1:0] sum;
        prod = d * $signed({1'b0, t});
        sum  = {{(DIFF_W+T_W+2-COORD_W-16){p[COORD_W-1]}}, p, 16'h0000}
             + {prod[DIFF_W+T_W], prod};
        return sum[FIX_W-1:0];
    endfunction

    // later rounds: a + floor(diff * t / 2^16)
    function automatic logic signed [FIX_W-1:0] lerp(
        input logic signed [FIX_W-1:0] a,
        input logic signed [FIX_W:0]   diff,
        input logic        [T_W-1:0]   t
    );
        logic signed [FIX_W+T_W+1:0] prod;
        logic        [FIX_W+T_W-15:0] sum;
        prod = diff * $signed({1'b0, t});
        sum  = {{(T_W-14){a[FIX_W-1]}}, a} + prod[FIX_W+T_W+1:16];
        return sum[FIX_W-1:0];
    endfunction

    // configuration
    logic [CFG_W-1:0] r_step_dist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_dist <= CFG_STEP_RESET;
        end else if (i_cfg_we) begin
            r_step_dist <= i_cfg_wdata;
        end
    end

    // curve registers, lane 0 is x and lane 1 is y
    logic signed [COORD_W-1:0] r_p0 [2];
    logic signed [COORD_W-1:0] r_p1 [2];
    logic signed [COORD_W-1:0] r_p2 [2];
    logic signed [DIFF_W-1:0]  r_d01 [2];
    logic signed [DIFF_W-1:0]  r_d12 [2];
    logic signed [DIFF_W-1:0]  r_d23 [2];
    logic        [DIST_W-1:0]  r_dist [3];
    logic        [DIST_W-1:0]  r_maxd;

    logic signed [COORD_W-1:0] in_p [2][4];
    always_comb begin
        in_p[0][0] = i_start_x;  in_p[1][0] = i_start_y;
        in_p[0][1] = i_ctrl1_x;  in_p[1][1] = i_ctrl1_y;
        in_p[0][2] = i_ctrl2_x;  in_p[1][2] = i_ctrl2_y;
        in_p[0][3] = i_end_x;    in_p[1][3] = i_end_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 2; k++) begin
                r_p0[k]  <= in_p[k][0];
                r_p1[k]  <= in_p[k][1];
                r_p2[k]  <= in_p[k][2];
                r_d01[k] <= DIFF_W'(in_p[k][1]) - DIFF_W'(in_p[k][0]);
                r_d12[k] <= DIFF_W'(in_p[k][2]) - DIFF_W'(in_p[k][1]);
                r_d23[k] <= DIFF_W'(in_p[k][3]) - DIFF_W'(in_p[k][2]);
            end
        end
    end

    // taxicab distance of each neighbor pair, then the largest
    function automatic logic [DIFF_W-1:0] absv(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.sums) begin
            r_dist[0] <= DIST_W'(absv(r_d01[0])) + DIST_W'(absv(r_d01[1]));
            r_dist[1] <= DIST_W'(absv(r_d12[0])) + DIST_W'(absv(r_d12[1]));
            r_dist[2] <= DIST_W'(absv(r_d23[0])) + DIST_W'(absv(r_d23[1]));
        end
        if (i_cmd.maxd) begin
            if (r_dist[0] >= r_dist[1] && r_dist[0] >= r_dist[2]) begin
                r_maxd <= r_dist[0];
            end else if (r_dist[1] >= r_dist[2]) begin
                r_maxd <= r_dist[1];
            end else begin
                r_maxd <= r_dist[2];
            end
        end
    end

    // shared divider: step count, then the per-step t increment
    logic [IDX_W-1:0] r_steps;
    logic [DIV_W-1:0] div_dividend;
    logic [CFG_W-1:0] div_divisor;
    logic             div_busy;
    logic [DIV_W-1:0] div_quot;
    logic [CFG_W-1:0] div_rem;

    always_comb begin
        if (i_cmd.div_sel == DIV_RECIP) begin
            div_dividend = T_ONE;
            div_divisor  = CFG_W'(r_steps);
        end else begin
            div_dividend = r_maxd;
            div_divisor  = (r_step_dist == '0) ? CFG_W'(1) : r_step_dist;
        end
    end

    cbf_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.steps_latch) begin
            if (div_quot > DIV_W'(MAX_STEPS)) begin
                r_steps <= IDX_W'(MAX_STEPS);
            end else if (div_quot == '0) begin
                r_steps <= IDX_W'(1);
            end else begin
                r_steps <= div_quot[IDX_W-1:0];
            end
        end
    end

    // t walk: t += Q with a carry from the running remainder
    logic [T_W-1:0]   r_q;
    logic [IDX_W-1:0] r_r;
    logic [T_W-1:0]   r_t;
    logic [IDX_W-1:0] r_trem;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W:0]   rem_sum;
    logic             rem_carry;
    logic             walk_last;

    always_comb begin
        rem_sum   = {1'b0, r_trem} + {1'b0, r_r};
        rem_carry = rem_sum >= {1'b0, r_steps};
        walk_last = r_idx == r_steps;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_q    <= div_quot[T_W-1:0];
            r_r    <= div_rem[IDX_W-1:0];
            r_t    <= '0;
            r_trem <= '0;
            r_idx  <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + IDX_W'(1);
            if (rem_carry) begin
                r_t    <= r_t + r_q + T_W'(1);
                r_trem <= IDX_W'(rem_sum - {1'b0, r_steps});
            end else begin
                r_t    <= r_t + r_q;
                r_trem <= rem_sum[IDX_W-1:0];
            end
        end
    end

    // evaluation pipeline, all stages move together
    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;
    logic [T_W-1:0]   r_t1, r_t2, r_t3, r_t4;
    logic [IDX_W-1:0] r_i1, r_i2, r_i3, r_i4, r_i5;
    logic             r_l1, r_l2, r_l3, r_l4, r_l5;

    logic signed [FIX_W-1:0] r_s1_a [2];
    logic signed [FIX_W-1:0] r_s1_b [2];
    logic signed [FIX_W-1:0] r_s1_c [2];
    logic signed [FIX_W-1:0] r_s2_a [2];
    logic signed [FIX_W-1:0] r_s2_b [2];
    logic signed [FIX_W:0]   r_s2_ab [2];
    logic signed [FIX_W:0]   r_s2_bc [2];
    logic signed [FIX_W-1:0] r_s3_d [2];
    logic signed [FIX_W-1:0] r_s3_e [2];
    logic signed [FIX_W-1:0] r_s4_d [2];
    logic signed [FIX_W:0]   r_s4_de [2];
    logic signed [FIX_W-1:0] r_s5_f [2];
    logic signed [COORD_W-1:0] r_out [2];

    logic [FIX_W:0]     rnd_sum [2];
    logic [COORD_W:0]   rnd_int [2];
    logic [COORD_W-1:0] rnd_sat [2];

    assign adv = !r_vo || !i_out_stall;

    // round to nearest, ties up, then saturate
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            rnd_sum[k] = {r_s5_f[k][FIX_W-1], r_s5_f[k]} + (FIX_W+1)'(32768);
            rnd_int[k] = rnd_sum[k][FIX_W:16];
            if (rnd_int[k][COORD_W] != rnd_int[k][COORD_W-1]) begin
                rnd_sat[k] = rnd_int[k][COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                                 : {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                rnd_sat[k] = rnd_int[k][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_vo <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t1 <= r_t;  r_i1 <= r_idx; r_l1 <= walk_last;
            r_t2 <= r_t1; r_i2 <= r_i1;  r_l2 <= r_l1;
            r_t3 <= r_t2; r_i3 <= r_i2;  r_l3 <= r_l2;
            r_t4 <= r_t3; r_i4 <= r_i3;  r_l4 <= r_l3;
            r_i5 <= r_i4; r_l5 <= r_l4;
            o_point_index <= r_i5;
            o_last        <= r_l5;
            for (int k = 0; k < 2; k++) begin
                r_s1_a[k]  <= lerp_base(r_p0[k], r_d01[k], r_t);
                r_s1_b[k]  <= lerp_base(r_p1[k], r_d12[k], r_t);
                r_s1_c[k]  <= lerp_base(r_p2[k], r_d23[k], r_t);
                r_s2_a[k]  <= r_s1_a[k];
                r_s2_b[k]  <= r_s1_b[k];
                r_s2_ab[k] <= (FIX_W+1)'(r_s1_b[k]) - (FIX_W+1)'(r_s1_a[k]);
                r_s2_bc[k] <= (FIX_W+1)'(r_s1_c[k]) - (FIX_W+1)'(r_s1_b[k]);
                r_s3_d[k]  <= lerp(r_s2_a[k], r_s2_ab[k], r_t2);
                r_s3_e[k]  <= lerp(r_s2_b[k], r_s2_bc[k], r_t2);
                r_s4_d[k]  <= r_s3_d[k];
                r_s4_de[k] <= (FIX_W+1)'(r_s3_e[k]) - (FIX_W+1)'(r_s3_d[k]);
                r_s5_f[k]  <= lerp(r_s4_d[k], r_s4_de[k], r_t4);
                r_out[k]   <= rnd_sat[k];
            end
        end
    end

    always_comb begin
        o_status.div_busy  = div_busy;
        o_status.adv       = adv;
        o_status.walk_last = walk_last;
    end

    assign o_out_valid = r_vo;
    assign o_point_x   = r_out[0];
    assign o_point_y   = r_out[1];

endmodule

FILE: hw/rtl/cubic_bezier_flattener.sv
// Cubic curve flattener.
// Input channel (i_in_valid / o_in_stall): one word carries the start point,
// both control points and the end point, 16-bit signed pixels each.
// Output channel (o_out_valid / i_out_stall): one word per sample point with
// x, y, the sample index and a last flag on the final point of the curve.
// Config: i_cfg_we / i_cfg_wdata write the step distance (reset value 8,
// zero acts as one); write it only while the block is idle.
// The step count is the largest taxicab distance between neighboring points
// divided by the step distance, limited to MAX_STEPS, raised to at least one.
// Flow: one curve at a time. Distances and their maximum, then two runs
// of a bit-serial divider (step count, then the t increment), before the
// first point enters a 6-stage evaluation pipe.
// Points then leave one per cycle while the receiver does not stall: a curve
// of N steps gives N+1 words, and the next curve is taken once the last point
// has entered the pipe.
// A stall freezes the whole evaluation pipe and the point issue; results are
// held, never dropped. Synchronous reset empties the pipe, returns the
// controller to idle and restores the step distance; the input stalls meanwhile.
module cubic_bezier_flattener #(
    parameter int MAX_STEPS = 63
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [cbf_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl1_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl1_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl2_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_ctrl2_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] i_end_y,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [cbf_pkg::COORD_W-1:0] o_point_x,
    output logic signed [cbf_pkg::COORD_W-1:0] o_point_y,
    output logic        [cbf_pkg::IDX_W-1:0]   o_point_index,
    output logic                               o_last
);
    import cbf_pkg::*;

    t_cmd    cmd;
    t_status status;

    cbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cbf_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_ctrl1_x     (i_ctrl1_x),
        .i_ctrl1_y     (i_ctrl1_y),
        .i_ctrl2_x     (i_ctrl2_x),
        .i_ctrl2_y     (i_ctrl2_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_index (o_point_index),
        .o_last        (o_last)
    );

endmodule
